// ----- sv/byte_histogram_bar_scaler_core_assert.svh -----
`ifndef BYTE_HISTOGRAM_BAR_SCALER_CORE_ASSERT_SVH
`define BYTE_HISTOGRAM_BAR_SCALER_CORE_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define BHBS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define BHBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BHBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bhbs_pkg.sv -----
package bhbs_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int BAR_MAX_DEF    = 511;

    localparam int BIN_NUM        = 256;
    localparam int IDX_BITS       = 8;
    localparam int OP_BITS        = 2;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OUT_BAR_BITS   = 9;
    localparam int OUT_DATA_BITS  = 80;

    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_ACCUM = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_DBL,
        DIV_ADD,
        DIV_DONE
    } t_div_state;

endpackage

// ----- sv/byte_histogram_bar_scaler_core.sv -----
// 256-bin histogram of 8-bit pixels with a bar-length read-out. Accumulate
// transactions (tuser 0) are taken one per cycle back to back while no read is under
// way: the bin store is a single-port-read memory with a registered read, and the
// read-modify-write forwards the last written count when consecutive pixels hit the
// same bin. Reset and a clear (tuser 2) empty the store through per-bin valid bits,
// so no clearing pass follows reset. A read (tuser 1) holds off input while the
// bit-serial scaling loop runs a doubling step and an adding step for each bar bit,
// and its result waits in an output register; a result still held there stretches
// the stall. tuser 3 is ignored. Counters saturate at all ones; the peak never
// drops below one.
`include "byte_histogram_bar_scaler_core_assert.svh"

module byte_histogram_bar_scaler_core #(
    parameter int COUNT_BITS = bhbs_pkg::COUNT_BITS_DEF,
    parameter int BAR_MAX    = bhbs_pkg::BAR_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [31:0] bin_count, [40:32] bar_length,
                                        // [72:41] peak_count, [79:73] zero
);

    localparam int QBITS   = $clog2(BAR_MAX + 1);
    localparam int IBITS   = (QBITS > 1) ? $clog2(QBITS) : 1;
    localparam int CNT_EXT = (COUNT_BITS > bhbs_pkg::OUT_COUNT_BITS) ?
                             COUNT_BITS : bhbs_pkg::OUT_COUNT_BITS;
    localparam int BAR_EXT = (QBITS > bhbs_pkg::OUT_BAR_BITS) ? QBITS : bhbs_pkg::OUT_BAR_BITS;
    localparam logic [QBITS-1:0] BAR_MAX_V = QBITS'(BAR_MAX);
    localparam logic [IBITS-1:0] BIT_TOP   = IBITS'(QBITS - 1);

    // bin store
    logic [COUNT_BITS-1:0]          r_mem [0:bhbs_pkg::BIN_NUM-1];
    logic [bhbs_pkg::BIN_NUM-1:0]   r_valid;
    logic [COUNT_BITS-1:0]          r_rd_data;
    logic                           r_rd_vld;

    // second stage
    logic                           r_s2_vld;
    bhbs_pkg::t_op                  r_s2_op;
    logic [bhbs_pkg::IDX_BITS-1:0]  r_s2_idx;

    // forwarding of the previous cycle's update
    logic                           r_fwd_wr;
    logic                           r_fwd_clr;
    logic [bhbs_pkg::IDX_BITS-1:0]  r_fwd_idx;
    logic [COUNT_BITS-1:0]          r_fwd_data;

    logic [COUNT_BITS-1:0]          r_peak;

    // bar scaling
    bhbs_pkg::t_div_state           r_state;
    bhbs_pkg::t_div_state           n_state;
    logic [COUNT_BITS-1:0]          r_cnt;
    logic [COUNT_BITS-1:0]          r_dpeak;
    logic [COUNT_BITS-1:0]          r_gap;
    logic [COUNT_BITS-1:0]          r_rem;
    logic [QBITS-1:0]               r_q;
    logic [IBITS-1:0]               r_bit;

    // output register
    logic                                  r_out_vld;
    logic [bhbs_pkg::OUT_COUNT_BITS-1:0]   r_out_count;
    logic [bhbs_pkg::OUT_BAR_BITS-1:0]     r_out_bar;
    logic [bhbs_pkg::OUT_COUNT_BITS-1:0]   r_out_peak;

    logic                    in_acc;
    logic                    s2_acc;
    logic                    s2_rd;
    logic                    s2_clr;
    logic [COUNT_BITS-1:0]   s2_count;
    logic [COUNT_BITS-1:0]   s2_inc;
    logic [COUNT_BITS+1:0]   dbl_sub;
    logic [COUNT_BITS:0]     add_sub;
    logic                    out_load;
    logic [QBITS-1:0]        bar_q;
    logic [BAR_EXT-1:0]      bar_ext;
    logic [CNT_EXT-1:0]      cnt_ext;
    logic [CNT_EXT-1:0]      peak_ext;

    assign s_axis_tready = (r_state == bhbs_pkg::DIV_IDLE) &&
                           !(r_s2_vld && (r_s2_op == bhbs_pkg::OP_READ));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s2_acc = r_s2_vld && (r_s2_op == bhbs_pkg::OP_ACCUM);
    assign s2_rd  = r_s2_vld && (r_s2_op == bhbs_pkg::OP_READ);
    assign s2_clr = r_s2_vld && (r_s2_op == bhbs_pkg::OP_CLEAR);

    // the read was issued on the edge that committed the previous update
    always_comb begin
        if (r_fwd_clr) begin
            s2_count = '0;
        end else if (r_fwd_wr && (r_fwd_idx == r_s2_idx)) begin
            s2_count = r_fwd_data;
        end else if (r_rd_vld) begin
            s2_count = r_rd_data;
        end else begin
            s2_count = '0;
        end
    end

    assign s2_inc = (&s2_count) ? s2_count : s2_count + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_mem[s_axis_tdata];
            r_rd_vld  <= r_valid[s_axis_tdata];
            r_s2_op   <= s_axis_tuser;
            r_s2_idx  <= s_axis_tdata;
        end
        if (s2_acc) begin
            r_mem[r_s2_idx] <= s2_inc;
        end
        r_fwd_idx  <= r_s2_idx;
        r_fwd_data <= s2_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_s2_vld  <= 1'b0;
            r_fwd_wr  <= 1'b0;
            r_fwd_clr <= 1'b0;
            r_peak    <= COUNT_BITS'(1);
        end else begin
            r_s2_vld  <= in_acc;
            r_fwd_wr  <= s2_acc;
            r_fwd_clr <= s2_clr;
            if (s2_clr) begin
                r_valid <= '0;
                r_peak  <= COUNT_BITS'(1);
            end else if (s2_acc) begin
                r_valid[r_s2_idx] <= 1'b1;
                if (s2_inc > r_peak) begin
                    r_peak <= s2_inc;
                end
            end
        end
    end

    // scaling step: doubling half and count-adding half of one bar bit
    assign dbl_sub = {1'b0, r_rem, 1'b0} - {2'b00, r_dpeak};
    assign add_sub = {1'b0, r_rem} - {1'b0, r_gap};

    always_comb begin
        n_state = r_state;
        case (r_state)
            bhbs_pkg::DIV_IDLE: begin
                if (s2_rd) begin
                    n_state = bhbs_pkg::DIV_DBL;
                end
            end
            bhbs_pkg::DIV_DBL: begin
                n_state = bhbs_pkg::DIV_ADD;
            end
            bhbs_pkg::DIV_ADD: begin
                if (r_bit == '0) begin
                    n_state = bhbs_pkg::DIV_DONE;
                end else begin
                    n_state = bhbs_pkg::DIV_DBL;
                end
            end
            bhbs_pkg::DIV_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_state = bhbs_pkg::DIV_IDLE;
                end
            end
            default: begin
                n_state = bhbs_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        case (r_state)
            bhbs_pkg::DIV_DONE: out_load = !r_out_vld || m_axis_tready;
            default:            out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhbs_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bhbs_pkg::DIV_IDLE: begin
                if (s2_rd) begin
                    r_cnt   <= s2_count;
                    r_dpeak <= r_peak;
                    r_gap   <= r_peak - s2_count;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_bit   <= BIT_TOP;
                end
            end
            bhbs_pkg::DIV_DBL: begin
                if (!dbl_sub[COUNT_BITS+1]) begin
                    r_rem <= dbl_sub[COUNT_BITS-1:0];
                    r_q   <= (r_q << 1) | QBITS'(1);
                end else begin
                    r_rem <= {r_rem[COUNT_BITS-2:0], 1'b0};
                    r_q   <= r_q << 1;
                end
            end
            bhbs_pkg::DIV_ADD: begin
                if (BAR_MAX_V[r_bit]) begin
                    if (!add_sub[COUNT_BITS]) begin
                        r_rem <= add_sub[COUNT_BITS-1:0];
                        r_q   <= r_q + QBITS'(1);
                    end else begin
                        r_rem <= r_rem + r_cnt;
                    end
                end
                r_bit <= r_bit - IBITS'(1);
            end
            default: begin
            end
        endcase
    end

    // a nonzero count never shows an empty bar
    assign bar_q    = ((r_q == '0) && (r_cnt != '0)) ? QBITS'(1) : r_q;
    assign bar_ext  = BAR_EXT'(bar_q);
    assign cnt_ext  = CNT_EXT'(r_cnt);
    assign peak_ext = CNT_EXT'(r_dpeak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= cnt_ext[bhbs_pkg::OUT_COUNT_BITS-1:0];
            r_out_bar   <= bar_ext[bhbs_pkg::OUT_BAR_BITS-1:0];
            r_out_peak  <= peak_ext[bhbs_pkg::OUT_COUNT_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out_peak, r_out_bar, r_out_count};

    `BHBS_ASSERT_ALWAYS(a_peak_nonzero, i_clk, i_rst_n, r_peak != '0, "running peak is zero")
    `BHBS_ASSERT_IMPLY(a_busy_stalls_input, i_clk, i_rst_n, r_state != bhbs_pkg::DIV_IDLE, !s_axis_tready, "input taken while scaling")
    `BHBS_ASSERT_NEXT(a_clear_resets_peak, i_clk, i_rst_n, s2_clr, r_peak == COUNT_BITS'(1), "peak not reset by clear")
    `BHBS_ASSERT_IMPLY(a_rem_below_peak, i_clk, i_rst_n, r_state == bhbs_pkg::DIV_DBL || r_state == bhbs_pkg::DIV_ADD, r_rem < r_dpeak, "scaling remainder out of range")
    `BHBS_ASSERT_IMPLY(a_bar_in_range, i_clk, i_rst_n, r_state == bhbs_pkg::DIV_DONE, r_q <= BAR_MAX_V, "bar length above maximum")

endmodule
